>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the heap queue datapath and controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> hw/rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// Heap queue package
// Shared constants, codes and control structures of the heap queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mhpq_pkg;
   localparam int unsigned DefaultDepth = 32;
   localparam int unsigned KeyWidth     = 32;
   localparam int unsigned CapWidth     = 6;
   localparam int unsigned StatusWidth  = 4;
   localparam logic [CapWidth-1:0] CapReset = 6'd32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_FIND   = 2'd2,
      CMD_PRINT  = 2'd3
   } cmd_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_INSERTED  = 4'd0,
      ST_DUPLICATE = 4'd1,
      ST_FULL      = 4'd2,
      ST_DELETED   = 4'd3,
      ST_EMPTY     = 4'd4,
      ST_FOUND     = 4'd5,
      ST_NOT_FOUND = 4'd6,
      ST_PRINTED   = 4'd7,
      ST_PRINT_NONE = 4'd8
   } status_type;

   // Address source for the memory read port.
   typedef enum logic [2:0] {
      RA_SCAN, RA_SCAN_NEXT, RA_PARENT, RA_ROOT, RA_TAIL, RA_LEFT, RA_RIGHT
   } raddr_sel_type;

   // Address source for the memory write port.
   typedef enum logic [1:0] {
      WA_POS, WA_CHILD
   } waddr_sel_type;

   // Data source for the memory write port.
   typedef enum logic [1:0] {
      WD_KEY, WD_RDATA, WD_TAIL, WD_BEST
   } wdata_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          load_req;
      logic          scan_clear;
      logic          scan_step;
      raddr_sel_type raddr_sel;
      logic          rd_en;
      logic          wr_en;
      waddr_sel_type waddr_sel;
      wdata_sel_type wdata_sel;
      logic          pos_to_count;   // insert: position = new count
      logic          pos_to_one;     // delete: position = root
      logic          pos_to_parent;
      logic          pos_to_child;
      logic          count_inc;
      logic          count_dec;
      logic          cap_write;
      logic          save_top;
      logic          save_tail;
      logic          save_left;
      logic          pick_child;     // compare left and right reads
      logic          out_valid;
      status_type    out_status;
      logic          out_use_rdata;  // value from memory read
      logic          out_use_top;
      logic          out_zero;
      logic          out_last_scan;  // last = scan at end of count
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type cmd;
      logic    count_zero;
      logic    full;
      logic    scan_done;      // scan index has reached count
      logic    match;          // registered read equals the key
      logic    pos_is_root;
      logic    parent_less;    // registered parent read < key
      logic    has_left;       // 2*pos <= count
      logic    has_right;      // 2*pos+1 <= count
      logic    child_greater;  // chosen child > tail
   } dp_status_type;
endpackage
`default_nettype wire

>>> hw/rtl/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// Max-heap priority queue
// Binary max-heap of signed keys with insert, delete-max, find and print.
// ----------------------------------------------------------------------------
// Sequencing: insert and find scan the stored entries, then insert sifts the
// new key up level by level; delete sifts the tail down level by level; print
// gives one item per cycle. All sequencing runs through one memory read port.
// Throughput: one command at a time; busy is high until its last item.
// Reset: synchronous; the heap is empty and capacity is 32. Items cannot be
// stalled by the receiver. Memory contents need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module max_heap_priority_queue
   import mhpq_pkg::*;
#(
   parameter int unsigned DEPTH = DefaultDepth
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [1:0]            req_cmd,
   input  wire logic signed [KeyWidth-1:0] req_key,
   input  wire logic                  csr_we,
   input  wire logic [CapWidth-1:0]   csr_wdata,
   output logic                       rsp_valid,
   output logic [StatusWidth-1:0]     rsp_status,
   output logic signed [KeyWidth-1:0] rsp_value,
   output logic                       rsp_last
);
   // The controller steps the memory one access per cycle; the datapath holds
   // count, capacity, positions and the result register.
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   mhpq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .csr_we   (csr_we),
      .dp_status(dp_status),
      .dp_cmd   (dp_cmd),
      .busy     (busy)
   );

   mhpq_datapath #(.DEPTH(DEPTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_cmd   (req_cmd),
      .req_key   (req_key),
      .csr_wdata (csr_wdata),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_status(rsp_status),
      .rsp_value (rsp_value),
      .rsp_last  (rsp_last)
   );
endmodule
`default_nettype wire

>>> hw/rtl/mhpq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mhpq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/mhpq_datapath.sv
// ----------------------------------------------------------------------------
// Heap queue datapath
// Count, capacity, position registers, heap memory and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mhpq_datapath
   import mhpq_pkg::*;
#(
   parameter int unsigned DEPTH = DefaultDepth
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [1:0]            req_cmd,
   input  wire logic signed [KeyWidth-1:0] req_key,
   input  wire logic [CapWidth-1:0]   csr_wdata,
   input  wire dp_cmd_type            dp_cmd,
   output dp_status_type              dp_status,
   output logic                       rsp_valid,
   output logic [StatusWidth-1:0]     rsp_status,
   output logic signed [KeyWidth-1:0] rsp_value,
   output logic                       rsp_last
);
   // Positions are 1-based; CW holds 0..DEPTH and twice that for child math.
   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1) + 1;

   cmd_type                  cmd_ff;
   logic signed [KeyWidth-1:0] key_ff, top_ff, tail_ff, best_ff;
   logic [CW-1:0]            count_ff, pos_ff, scan_ff, child_ff;
   logic [CapWidth-1:0]      cap_ff;
   logic signed [KeyWidth-1:0] rdata;
   logic [AW-1:0]            raddr, waddr;
   logic [CW-1:0]            rpos, wpos, left_pos;
   logic signed [KeyWidth-1:0] wdata;
   logic [CW:0]              cap_ext, depth_ext;
   logic                     right_wins;
   logic                     count_cmd;

   assign left_pos = {pos_ff[CW-2:0], 1'b0};

   always_comb begin
      case (dp_cmd.raddr_sel)
         RA_SCAN:      rpos = scan_ff + CW'(1);
         RA_SCAN_NEXT: rpos = scan_ff + CW'(2);
         RA_PARENT:    rpos = {1'b0, pos_ff[CW-1:1]};
         RA_ROOT:      rpos = CW'(1);
         RA_TAIL:      rpos = count_ff;
         RA_LEFT:      rpos = left_pos;
         RA_RIGHT:     rpos = left_pos + CW'(1);
         default:      rpos = CW'(1);
      endcase
      case (dp_cmd.waddr_sel)
         WA_POS:   wpos = pos_ff;
         WA_CHILD: wpos = child_ff;
         default:  wpos = pos_ff;
      endcase
      case (dp_cmd.wdata_sel)
         WD_KEY:   wdata = key_ff;
         WD_RDATA: wdata = rdata;
         WD_TAIL:  wdata = tail_ff;
         WD_BEST:  wdata = best_ff;
         default:  wdata = key_ff;
      endcase
   end

   assign raddr = AW'(rpos - CW'(1));
   assign waddr = AW'(wpos - CW'(1));

   mhpq_ram #(.WIDTH(KeyWidth), .DEPTH(DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (dp_cmd.wr_en),
      .wr_addr(waddr),
      .wr_data(wdata),
      .rd_en  (dp_cmd.rd_en),
      .rd_addr(raddr),
      .rd_data(rdata)
   );

   assign right_wins = rdata > best_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cap_ff    <= CapReset;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= dp_cmd.out_valid;
         if (dp_cmd.cap_write) begin
            cap_ff   <= csr_wdata;
            count_ff <= '0;
         end else if (dp_cmd.count_inc) begin
            count_ff <= count_ff + CW'(1);
         end else if (dp_cmd.count_dec) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_req) begin
         cmd_ff <= cmd_type'(req_cmd);
         key_ff <= req_key;
      end
      if (dp_cmd.scan_clear) begin
         scan_ff <= '0;
      end else if (dp_cmd.scan_step) begin
         scan_ff <= scan_ff + CW'(1);
      end
      if (dp_cmd.pos_to_count) begin
         pos_ff <= count_ff + CW'(1);
      end else if (dp_cmd.pos_to_one) begin
         pos_ff <= CW'(1);
      end else if (dp_cmd.pos_to_parent) begin
         pos_ff <= {1'b0, pos_ff[CW-1:1]};
      end else if (dp_cmd.pos_to_child) begin
         pos_ff <= child_ff;
      end
      if (dp_cmd.save_top) begin
         top_ff <= rdata;
      end
      if (dp_cmd.save_tail) begin
         tail_ff <= rdata;
      end
      if (dp_cmd.save_left) begin
         best_ff  <= rdata;
         child_ff <= left_pos;
      end else if (dp_cmd.pick_child && right_wins) begin
         best_ff  <= rdata;
         child_ff <= left_pos + CW'(1);
      end
      if (dp_cmd.out_valid) begin
         rsp_status <= dp_cmd.out_status;
         rsp_last   <= dp_cmd.out_last_scan ? (scan_ff + CW'(1) == count_ff) : 1'b1;
         if (dp_cmd.out_zero) begin
            rsp_value <= '0;
         end else if (dp_cmd.out_use_top) begin
            rsp_value <= top_ff;
         end else if (dp_cmd.out_use_rdata) begin
            rsp_value <= rdata;
         end else begin
            rsp_value <= key_ff;
         end
      end
   end

   assign cap_ext   = (CW+1)'(cap_ff);
   assign depth_ext = (CW+1)'(DEPTH);

   always_comb begin
      dp_status.cmd           = cmd_ff;
      dp_status.count_zero    = (count_ff == '0);
      dp_status.full          = ((CW+1)'(count_ff) >= cap_ext) ||
                                ((CW+1)'(count_ff) >= depth_ext);
      dp_status.scan_done     = (scan_ff >= count_ff);
      dp_status.match         = (rdata == key_ff);
      dp_status.pos_is_root   = (pos_ff == CW'(1));
      dp_status.parent_less   = (rdata < key_ff);
      dp_status.has_left      = ((CW+1)'(left_pos) <= (CW+1)'(count_ff)) &&
                                !pos_ff[CW-1];
      dp_status.has_right     = ((CW+1)'(left_pos) + (CW+1)'(1) <= (CW+1)'(count_ff)) &&
                                !pos_ff[CW-1];
      dp_status.child_greater = (best_ff > tail_ff);
   end

   // Any command that may move the count.
   assign count_cmd = dp_cmd.cap_write | dp_cmd.count_inc | dp_cmd.count_dec;

   `include "assert_macros.svh"
   `ASSERT_IMPL(a_count_bound, clock, reset, (CW+1)'(count_ff) <= depth_ext)
   `ASSERT_IMPL(a_count_step, clock, reset, !$past(reset) && !$past(count_cmd) |-> $stable(count_ff))
   `ASSERT_IMPL(a_cap_clear, clock, reset, $past(dp_cmd.cap_write) |-> count_ff == '0)
endmodule
`default_nettype wire

>>> hw/rtl/mhpq_ctrl.sv
// ----------------------------------------------------------------------------
// Heap queue controller
// Sequences scan, sift-up, sift-down and print over the heap memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mhpq_ctrl
   import mhpq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    csr_we,
   input  dp_status_type dp_status,
   output dp_cmd_type   dp_cmd,
   output logic         busy
);
   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CHK, S_UP_RD, S_UP_CHK,
      S_DN_RD, S_DN_SAVE, S_DN_LEFT, S_DN_RIGHT, S_DN_PICK, S_DN_MOVE,
      S_PR_RD, S_PR_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_in;

   always_comb begin
      dp_cmd   = '0;
      state_in = state_ff;
      busy_in  = 1'b1;
      dp_cmd.raddr_sel = RA_SCAN;
      dp_cmd.waddr_sel = WA_POS;
      dp_cmd.wdata_sel = WD_KEY;
      dp_cmd.out_status = ST_INSERTED;
      dp_cmd.cap_write = csr_we;
      case (state_ff)
         S_IDLE: begin
            busy_in = 1'b0;
            if (start) begin
               dp_cmd.load_req   = 1'b1;
               dp_cmd.scan_clear = 1'b1;
               state_in = S_DISPATCH;
               busy_in  = 1'b1;
            end
         end
         S_DISPATCH: begin
            case (dp_status.cmd)
               CMD_INSERT, CMD_FIND: state_in = S_SCAN_RD;
               CMD_DELETE: begin
                  if (dp_status.count_zero) begin
                     dp_cmd.out_valid  = 1'b1;
                     dp_cmd.out_status = ST_EMPTY;
                     dp_cmd.out_zero   = 1'b1;
                     state_in = S_IDLE;
                     busy_in  = 1'b0;
                  end else begin
                     dp_cmd.raddr_sel = RA_ROOT;
                     dp_cmd.rd_en     = 1'b1;
                     state_in = S_DN_RD;
                  end
               end
               default: begin
                  if (dp_status.count_zero) begin
                     dp_cmd.out_valid  = 1'b1;
                     dp_cmd.out_status = ST_PRINT_NONE;
                     dp_cmd.out_zero   = 1'b1;
                     state_in = S_IDLE;
                     busy_in  = 1'b0;
                  end else begin
                     state_in = S_PR_RD;
                  end
               end
            endcase
         end
         S_SCAN_RD: begin
            if (dp_status.scan_done) begin
               dp_cmd.out_valid = 1'b1;
               state_in = S_IDLE;
               busy_in  = 1'b0;
               if (dp_status.cmd == CMD_FIND) begin
                  dp_cmd.out_status = ST_NOT_FOUND;
               end else if (dp_status.full) begin
                  dp_cmd.out_status = ST_FULL;
               end else begin
                  // Start sift-up at the new last position.
                  dp_cmd.out_valid    = 1'b0;
                  dp_cmd.pos_to_count = 1'b1;
                  dp_cmd.count_inc    = 1'b1;
                  state_in = S_UP_RD;
                  busy_in  = 1'b1;
               end
            end else begin
               dp_cmd.raddr_sel = RA_SCAN;
               dp_cmd.rd_en     = 1'b1;
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            dp_cmd.scan_step = 1'b1;
            state_in = S_SCAN_RD;
            if (dp_status.match) begin
               dp_cmd.out_valid  = 1'b1;
               dp_cmd.out_status = (dp_status.cmd == CMD_FIND) ? ST_FOUND : ST_DUPLICATE;
               state_in = S_IDLE;
               busy_in  = 1'b0;
            end
         end
         S_UP_RD: begin
            if (dp_status.pos_is_root) begin
               dp_cmd.wr_en     = 1'b1;
               dp_cmd.out_valid = 1'b1;
               state_in = S_IDLE;
               busy_in  = 1'b0;
            end else begin
               dp_cmd.raddr_sel = RA_PARENT;
               dp_cmd.rd_en     = 1'b1;
               state_in = S_UP_CHK;
            end
         end
         S_UP_CHK: begin
            if (dp_status.parent_less) begin
               dp_cmd.wr_en         = 1'b1;
               dp_cmd.wdata_sel     = WD_RDATA;
               dp_cmd.pos_to_parent = 1'b1;
               state_in = S_UP_RD;
            end else begin
               dp_cmd.wr_en     = 1'b1;
               dp_cmd.out_valid = 1'b1;
               state_in = S_IDLE;
               busy_in  = 1'b0;
            end
         end
         S_DN_RD: begin
            // Root read is back; fetch the tail next.
            dp_cmd.save_top  = 1'b1;
            dp_cmd.raddr_sel = RA_TAIL;
            dp_cmd.rd_en     = 1'b1;
            state_in = S_DN_SAVE;
         end
         S_DN_SAVE: begin
            dp_cmd.save_tail  = 1'b1;
            dp_cmd.count_dec  = 1'b1;
            dp_cmd.pos_to_one = 1'b1;
            state_in = S_DN_LEFT;
         end
         S_DN_LEFT: begin
            if (dp_status.has_left) begin
               dp_cmd.raddr_sel = RA_LEFT;
               dp_cmd.rd_en     = 1'b1;
               state_in = S_DN_RIGHT;
            end else begin
               dp_cmd.wr_en     = !dp_status.count_zero;
               dp_cmd.wdata_sel = WD_TAIL;
               dp_cmd.out_valid = 1'b1;
               dp_cmd.out_status = ST_DELETED;
               dp_cmd.out_use_top = 1'b1;
               state_in = S_IDLE;
               busy_in  = 1'b0;
            end
         end
         S_DN_RIGHT: begin
            dp_cmd.save_left = 1'b1;
            if (dp_status.has_right) begin
               dp_cmd.raddr_sel = RA_RIGHT;
               dp_cmd.rd_en     = 1'b1;
               state_in = S_DN_PICK;
            end else begin
               state_in = S_DN_MOVE;
            end
         end
         S_DN_PICK: begin
            dp_cmd.pick_child = 1'b1;
            state_in = S_DN_MOVE;
         end
         S_DN_MOVE: begin
            if (dp_status.child_greater) begin
               dp_cmd.wr_en        = 1'b1;
               dp_cmd.wdata_sel    = WD_BEST;
               dp_cmd.pos_to_child = 1'b1;
               state_in = S_DN_LEFT;
            end else begin
               dp_cmd.wr_en     = 1'b1;
               dp_cmd.wdata_sel = WD_TAIL;
               dp_cmd.out_valid = 1'b1;
               dp_cmd.out_status = ST_DELETED;
               dp_cmd.out_use_top = 1'b1;
               state_in = S_IDLE;
               busy_in  = 1'b0;
            end
         end
         S_PR_RD: begin
            dp_cmd.raddr_sel = RA_SCAN;
            dp_cmd.rd_en     = 1'b1;
            state_in = S_PR_OUT;
         end
         S_PR_OUT: begin
            dp_cmd.out_valid     = 1'b1;
            dp_cmd.out_status    = ST_PRINTED;
            dp_cmd.out_use_rdata = 1'b1;
            dp_cmd.out_last_scan = 1'b1;
            dp_cmd.scan_step     = 1'b1;
            if (dp_status.scan_done) begin
               dp_cmd.out_valid = 1'b0;
               state_in = S_IDLE;
               busy_in  = 1'b0;
            end else begin
               // Prefetch the element after the one going out now.
               dp_cmd.raddr_sel = RA_SCAN_NEXT;
               dp_cmd.rd_en     = 1'b1;
               state_in = S_PR_OUT;
            end
         end
         default: begin
            state_in = S_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy     <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy     <= busy_in;
      end
   end

   `include "assert_macros.svh"
   `ASSERT_IMPL(a_busy_state, clock, reset, busy == (state_ff != S_IDLE))
   `ASSERT_IMPL(a_start_leaves_idle, clock, reset, start && !busy |=> state_ff == S_DISPATCH)
   `ASSERT_IMPL(a_single_write, clock, reset, dp_cmd.wr_en |-> !dp_cmd.scan_step)
endmodule
`default_nettype wire
